[hdl/ihp_pkg.sv]
// ----------------------------------------------------------------------------
// ihp_pkg: shared types and constants of the indexed min-heap unit
// Request and status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package ihp_pkg;

    localparam int IHP_CAPACITY  = 1024;
    localparam int IHP_KEY_WIDTH = 32;

    typedef logic [2:0] req_t;
    typedef logic [1:0] status_t;

    localparam req_t REQ_INSERT     = 3'd0;
    localparam req_t REQ_PEEK       = 3'd1;
    localparam req_t REQ_DEL_MIN    = 3'd2;
    localparam req_t REQ_DEL_HANDLE = 3'd3;
    localparam req_t REQ_MODIFY     = 3'd4;

    localparam status_t STAT_OK         = 2'd0;
    localparam status_t STAT_EMPTY      = 2'd1;
    localparam status_t STAT_BAD_HANDLE = 2'd2;
    localparam status_t STAT_FULL       = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DECIDE,
        ST_REM_RD,
        ST_REM_SET,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_RDL,
        ST_DN_RDR,
        ST_DN_CMP,
        ST_WRITE,
        ST_MIN_RD,
        ST_REPORT
    } state_t;

endpackage

[hdl/ihp_ram.sv]
// ----------------------------------------------------------------------------
// ihp_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ihp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/indexed_min_heap_unit.sv]
// ----------------------------------------------------------------------------
// indexed_min_heap_unit: binary min-heap of signed keys with handles
// Sequencer over key, owner, slot and live memories with signed key comparators.
// ----------------------------------------------------------------------------
// Usage:
//   Present req_type, handle and key_value with start high while busy is low;
//   the word is taken at that edge and busy rises. Requests: insert, peek,
//   delete minimum, delete by handle, modify by handle.
//   One result word follows per request: done is high for exactly one cycle
//   with status, min_valid, min_key, new_handle and entry_count. The receiver
//   cannot stall; sample the result in the done cycle.
//   Each level walked up costs one read of the key and owner memories and
//   one compare against the moving key; each level walked down costs reads
//   of both children from those memories and a compare of the children
//   against the moving key. A new word can be given in the cycle done is high.
//   Reset empties the heap and restarts handles at 1; no clearing pass is
//   needed, memory contents are only used where they were written.
// ----------------------------------------------------------------------------
module indexed_min_heap_unit
    import ihp_pkg::*;
#(
    parameter int CAPACITY  = IHP_CAPACITY,
    parameter int KEY_WIDTH = IHP_KEY_WIDTH,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  req_type,
    input  logic [CW-1:0]               handle,
    input  logic signed [KEY_WIDTH-1:0] key_value,
    output logic                        done,
    output logic [1:0]                  status,
    output logic                        min_valid,
    output logic signed [KEY_WIDTH-1:0] min_key,
    output logic [CW-1:0]               new_handle,
    output logic [CW-1:0]               entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    state_t state_reg, state_next;
    req_t req_reg, req_next;
    logic [CW-1:0] h_reg, h_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] issued_reg, issued_next;
    logic [CW-1:0] cur_pos_reg, cur_pos_next;
    logic [KEY_WIDTH-1:0] cur_key_reg, cur_key_next;
    logic [CW-1:0] cur_owner_reg, cur_owner_next;
    logic [CW-1:0] tgt_pos_reg, tgt_pos_next;
    logic [CW-1:0] tgt_owner_reg, tgt_owner_next;
    logic [KEY_WIDTH-1:0] lkey_reg, lkey_next;
    logic [CW-1:0] lown_reg, lown_next;
    logic r_exists_reg, r_exists_next;
    logic moved_reg, moved_next;
    logic second_reg, second_next;
    status_t stat_reg, stat_next;
    logic [CW-1:0] given_reg, given_next;
    logic done_reg, done_next;
    status_t res_status_reg, res_status_next;
    logic res_valid_reg, res_valid_next;
    logic [KEY_WIDTH-1:0] res_key_reg, res_key_next;
    logic [CW-1:0] res_handle_reg, res_handle_next;
    logic [CW-1:0] res_count_reg, res_count_next;

    logic k_we, k_re, o_we, o_re, s_we, s_re, l_we, l_re;
    logic [AW-1:0] k_waddr, k_raddr, o_waddr, o_raddr, s_waddr, s_raddr, l_waddr, l_raddr;
    logic [KEY_WIDTH-1:0] k_wdata, k_rdata;
    logic [CW-1:0] o_wdata, o_rdata, s_wdata, s_rdata;
    logic [0:0] l_wdata, l_rdata;

    logic handle_ok;
    logic [CW:0] left_pos;
    logic [CW-1:0] parent_pos;
    logic l_less, r_less;
    logic [KEY_WIDTH-1:0] best_key;

    ihp_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_key_ram (
        .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
        .re(k_re), .raddr(k_raddr), .rdata(k_rdata)
    );

    ihp_ram #(.WIDTH(CW), .DEPTH(CAPACITY)) u_owner_ram (
        .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
        .re(o_re), .raddr(o_raddr), .rdata(o_rdata)
    );

    ihp_ram #(.WIDTH(CW), .DEPTH(CAPACITY)) u_slot_ram (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
    );

    ihp_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_live_ram (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .re(l_re), .raddr(l_raddr), .rdata(l_rdata)
    );

    assign handle_ok  = (h_reg != '0) && (h_reg <= issued_reg) && l_rdata[0];
    assign left_pos   = {cur_pos_reg, 1'b0};
    assign parent_pos = cur_pos_reg >> 1;
    assign l_less     = $signed(lkey_reg) < $signed(cur_key_reg);
    assign best_key   = l_less ? lkey_reg : cur_key_reg;
    assign r_less     = r_exists_reg && ($signed(k_rdata) < $signed(best_key));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            issued_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            issued_reg <= issued_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        h_reg          <= h_next;
        key_reg        <= key_next;
        cur_pos_reg    <= cur_pos_next;
        cur_key_reg    <= cur_key_next;
        cur_owner_reg  <= cur_owner_next;
        tgt_pos_reg    <= tgt_pos_next;
        tgt_owner_reg  <= tgt_owner_next;
        lkey_reg       <= lkey_next;
        lown_reg       <= lown_next;
        r_exists_reg   <= r_exists_next;
        moved_reg      <= moved_next;
        second_reg     <= second_next;
        stat_reg       <= stat_next;
        given_reg      <= given_next;
        res_status_reg <= res_status_next;
        res_valid_reg  <= res_valid_next;
        res_key_reg    <= res_key_next;
        res_handle_reg <= res_handle_next;
        res_count_reg  <= res_count_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        h_next          = h_reg;
        key_next        = key_reg;
        fill_next       = fill_reg;
        issued_next     = issued_reg;
        cur_pos_next    = cur_pos_reg;
        cur_key_next    = cur_key_reg;
        cur_owner_next  = cur_owner_reg;
        tgt_pos_next    = tgt_pos_reg;
        tgt_owner_next  = tgt_owner_reg;
        lkey_next       = lkey_reg;
        lown_next       = lown_reg;
        r_exists_next   = r_exists_reg;
        moved_next      = moved_reg;
        second_next     = second_reg;
        stat_next       = stat_reg;
        given_next      = given_reg;
        done_next       = 1'b0;
        res_status_next = res_status_reg;
        res_valid_next  = res_valid_reg;
        res_key_next    = res_key_reg;
        res_handle_next = res_handle_reg;
        res_count_next  = res_count_reg;
        k_we = 1'b0; k_waddr = '0; k_wdata = '0; k_re = 1'b0; k_raddr = '0;
        o_we = 1'b0; o_waddr = '0; o_wdata = '0; o_re = 1'b0; o_raddr = '0;
        s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_re = 1'b0; s_raddr = '0;
        l_we = 1'b0; l_waddr = '0; l_wdata = '0; l_re = 1'b0; l_raddr = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = req_type;
                    h_next     = handle;
                    key_next   = key_value;
                    stat_next  = STAT_OK;
                    given_next = '0;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                l_re = 1'b1; l_raddr = AW'(h_reg - ONE_C);
                s_re = 1'b1; s_raddr = AW'(h_reg - ONE_C);
                o_re = 1'b1; o_raddr = '0;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = ST_MIN_RD;
                case (req_reg)
                    REQ_INSERT:
                    begin
                        if ((fill_reg >= CAP_C) || (issued_reg >= CAP_C))
                        begin
                            stat_next = STAT_FULL;
                        end
                        else
                        begin
                            fill_next      = fill_reg + ONE_C;
                            issued_next    = issued_reg + ONE_C;
                            cur_pos_next   = fill_reg + ONE_C;
                            cur_key_next   = key_reg;
                            cur_owner_next = issued_reg + ONE_C;
                            given_next     = issued_reg + ONE_C;
                            l_we = 1'b1; l_waddr = AW'(issued_reg); l_wdata = 1'b1;
                            moved_next  = 1'b0;
                            second_next = 1'b0;
                            state_next  = ST_UP_RD;
                        end
                    end
                    REQ_PEEK:
                    begin
                        if (fill_reg == '0)
                        begin
                            stat_next = STAT_EMPTY;
                        end
                    end
                    REQ_DEL_MIN:
                    begin
                        if (fill_reg == '0)
                        begin
                            stat_next = STAT_EMPTY;
                        end
                        else
                        begin
                            tgt_pos_next   = ONE_C;
                            tgt_owner_next = o_rdata;
                            state_next     = ST_REM_RD;
                        end
                    end
                    REQ_DEL_HANDLE:
                    begin
                        if (!handle_ok)
                        begin
                            stat_next = STAT_BAD_HANDLE;
                        end
                        else
                        begin
                            tgt_pos_next   = s_rdata;
                            tgt_owner_next = h_reg;
                            state_next     = ST_REM_RD;
                        end
                    end
                    REQ_MODIFY:
                    begin
                        if (!handle_ok)
                        begin
                            stat_next = STAT_BAD_HANDLE;
                        end
                        else
                        begin
                            cur_pos_next   = s_rdata;
                            cur_key_next   = key_reg;
                            cur_owner_next = h_reg;
                            moved_next     = 1'b0;
                            second_next    = 1'b1;
                            state_next     = ST_UP_RD;
                        end
                    end
                    default:
                    begin
                        state_next = ST_MIN_RD;
                    end
                endcase
            end
            ST_REM_RD:
            begin
                // drop the handle and fetch the last entry to fill the hole
                l_we = 1'b1; l_waddr = AW'(tgt_owner_reg - ONE_C); l_wdata = 1'b0;
                k_re = 1'b1; k_raddr = AW'(fill_reg - ONE_C);
                o_re = 1'b1; o_raddr = AW'(fill_reg - ONE_C);
                fill_next  = fill_reg - ONE_C;
                state_next = ST_REM_SET;
            end
            ST_REM_SET:
            begin
                if (tgt_pos_reg > fill_reg)
                begin
                    state_next = ST_MIN_RD;
                end
                else
                begin
                    cur_pos_next   = tgt_pos_reg;
                    cur_key_next   = k_rdata;
                    cur_owner_next = o_rdata;
                    moved_next     = 1'b0;
                    second_next    = 1'b1;
                    state_next     = ST_DN_RDL;
                end
            end
            ST_UP_RD:
            begin
                if (cur_pos_reg == ONE_C)
                begin
                    if (second_reg && !moved_reg)
                    begin
                        second_next = 1'b0;
                        state_next  = ST_DN_RDL;
                    end
                    else
                    begin
                        state_next = ST_WRITE;
                    end
                end
                else
                begin
                    k_re = 1'b1; k_raddr = AW'(parent_pos - ONE_C);
                    o_re = 1'b1; o_raddr = AW'(parent_pos - ONE_C);
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                if ($signed(cur_key_reg) < $signed(k_rdata))
                begin
                    // move the parent down into the current slot
                    k_we = 1'b1; k_waddr = AW'(cur_pos_reg - ONE_C); k_wdata = k_rdata;
                    o_we = 1'b1; o_waddr = AW'(cur_pos_reg - ONE_C); o_wdata = o_rdata;
                    s_we = 1'b1; s_waddr = AW'(o_rdata - ONE_C); s_wdata = cur_pos_reg;
                    cur_pos_next = parent_pos;
                    moved_next   = 1'b1;
                    state_next   = ST_UP_RD;
                end
                else if (second_reg && !moved_reg)
                begin
                    second_next = 1'b0;
                    state_next  = ST_DN_RDL;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_DN_RDL:
            begin
                if (left_pos > {1'b0, fill_reg})
                begin
                    if (second_reg && !moved_reg)
                    begin
                        second_next = 1'b0;
                        state_next  = ST_UP_RD;
                    end
                    else
                    begin
                        state_next = ST_WRITE;
                    end
                end
                else
                begin
                    k_re = 1'b1; k_raddr = AW'(left_pos - 1'b1);
                    o_re = 1'b1; o_raddr = AW'(left_pos - 1'b1);
                    state_next = ST_DN_RDR;
                end
            end
            ST_DN_RDR:
            begin
                lkey_next     = k_rdata;
                lown_next     = o_rdata;
                r_exists_next = left_pos < {1'b0, fill_reg};
                if (left_pos < {1'b0, fill_reg})
                begin
                    k_re = 1'b1; k_raddr = AW'(left_pos);
                    o_re = 1'b1; o_raddr = AW'(left_pos);
                end
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                if (r_less || l_less)
                begin
                    // move the smaller child up into the current slot
                    k_we = 1'b1; k_waddr = AW'(cur_pos_reg - ONE_C);
                    k_wdata = r_less ? k_rdata : lkey_reg;
                    o_we = 1'b1; o_waddr = AW'(cur_pos_reg - ONE_C);
                    o_wdata = r_less ? o_rdata : lown_reg;
                    s_we = 1'b1;
                    s_waddr = AW'((r_less ? o_rdata : lown_reg) - ONE_C);
                    s_wdata = cur_pos_reg;
                    cur_pos_next = r_less ? CW'(left_pos + 1'b1) : CW'(left_pos);
                    moved_next   = 1'b1;
                    state_next   = ST_DN_RDL;
                end
                else if (second_reg && !moved_reg)
                begin
                    second_next = 1'b0;
                    state_next  = ST_UP_RD;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                k_we = 1'b1; k_waddr = AW'(cur_pos_reg - ONE_C); k_wdata = cur_key_reg;
                o_we = 1'b1; o_waddr = AW'(cur_pos_reg - ONE_C); o_wdata = cur_owner_reg;
                s_we = 1'b1; s_waddr = AW'(cur_owner_reg - ONE_C); s_wdata = cur_pos_reg;
                state_next = ST_MIN_RD;
            end
            ST_MIN_RD:
            begin
                k_re = 1'b1; k_raddr = '0;
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                res_status_next = stat_reg;
                res_valid_next  = fill_reg != '0;
                res_key_next    = (fill_reg != '0) ? k_rdata : '0;
                res_handle_next = given_reg;
                res_count_next  = fill_reg;
                done_next       = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy        = state_reg != ST_IDLE;
    assign done        = done_reg;
    assign status      = res_status_reg;
    assign min_valid   = res_valid_reg;
    assign min_key     = res_key_reg;
    assign new_handle  = res_handle_reg;
    assign entry_count = res_count_reg;

    a_done_after_report: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_REPORT))
        else $error("result word without report step");

    a_fill_le_issued: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= issued_reg)
        else $error("more entries than handles issued");

    a_issued_cap: assert property (@(posedge clk) disable iff (!rst_n)
        issued_reg <= CAP_C)
        else $error("handle counter beyond capacity");

    a_pos_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UP_RD || state_reg == ST_UP_CMP || state_reg == ST_DN_RDL
         || state_reg == ST_DN_RDR || state_reg == ST_DN_CMP || state_reg == ST_WRITE)
        |-> (cur_pos_reg != '0) && (cur_pos_reg <= fill_reg))
        else $error("sift position outside heap");

endmodule

[tb/indexed_min_heap_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_checker: result predictor and comparator of the heap unit
// Watches the request and result channels of indexed_min_heap_unit, keeps its
// own indexed heap, predicts one result word per accepted request and
// compares every result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module indexed_min_heap_checker
    import ihp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         req_type,
    input  logic [10:0]        handle,
    input  logic signed [31:0] key_value,
    input  logic               done,
    input  logic [1:0]         status,
    input  logic               min_valid,
    input  logic signed [31:0] min_key,
    input  logic [10:0]        new_handle,
    input  logic [10:0]        entry_count,
    output int                 errors,
    output int                 pending,
    output int                 checked
);

    typedef struct packed {
        status_t            status;
        logic               min_valid;
        logic signed [31:0] min_key;
        logic [10:0]        new_handle;
        logic [10:0]        entry_count;
    } heap_word_t;

    logic signed [31:0] heap_key [1:IHP_CAPACITY];
    int                 heap_owner [1:IHP_CAPACITY];
    int                 owner_slot [1:IHP_CAPACITY];
    bit                 owner_live [1:IHP_CAPACITY];
    int                 fill;
    int                 issued;
    heap_word_t         expected_words [$];

    function automatic void swap_slots(int a, int b);
        int                 ha;
        int                 hb;
        int                 ts;
        logic signed [31:0] tk;
        ha = heap_owner[a];
        hb = heap_owner[b];
        ts = owner_slot[ha];
        owner_slot[ha] = owner_slot[hb];
        owner_slot[hb] = ts;
        heap_owner[a] = hb;
        heap_owner[b] = ha;
        tk = heap_key[a];
        heap_key[a] = heap_key[b];
        heap_key[b] = tk;
    endfunction

    function automatic void sift_down(int pos);
        int best;
        int l;
        forever
        begin
            best = pos;
            l = 2 * pos;
            if (l <= fill && heap_key[l] < heap_key[best])
                best = l;
            if (l + 1 <= fill && heap_key[l + 1] < heap_key[best])
                best = l + 1;
            if (best == pos)
                return;
            swap_slots(best, pos);
            pos = best;
        end
    endfunction

    function automatic void sift_up(int pos);
        while (pos > 1 && heap_key[pos] < heap_key[pos / 2])
        begin
            swap_slots(pos, pos / 2);
            pos = pos / 2;
        end
    endfunction

    function automatic void drop_slot(int pos);
        owner_live[heap_owner[pos]] = 1'b0;
        swap_slots(pos, fill);
        fill--;
        if (pos <= fill)
        begin
            sift_down(pos);
            sift_up(pos);
        end
    endfunction

    function automatic heap_word_t apply_request(logic [2:0] r, int h,
                                                 logic signed [31:0] k);
        heap_word_t w;
        bit         h_ok;
        int         pos;
        w = '0;
        h_ok = h >= 1 && h <= issued && owner_live[h];
        case (r)
            REQ_INSERT:
                if (fill >= IHP_CAPACITY || issued >= IHP_CAPACITY)
                    w.status = STAT_FULL;
                else
                begin
                    fill++;
                    issued++;
                    heap_key[fill] = k;
                    heap_owner[fill] = issued;
                    owner_slot[issued] = fill;
                    owner_live[issued] = 1'b1;
                    w.new_handle = issued[10:0];
                    sift_up(fill);
                end
            REQ_PEEK:
                if (fill == 0)
                    w.status = STAT_EMPTY;
            REQ_DEL_MIN:
                if (fill == 0)
                    w.status = STAT_EMPTY;
                else
                    drop_slot(1);
            REQ_DEL_HANDLE:
                if (!h_ok)
                    w.status = STAT_BAD_HANDLE;
                else
                    drop_slot(owner_slot[h]);
            REQ_MODIFY:
                if (!h_ok)
                    w.status = STAT_BAD_HANDLE;
                else
                begin
                    pos = owner_slot[h];
                    heap_key[pos] = k;
                    sift_up(pos);
                    sift_down(owner_slot[h]);
                end
            default: ;
        endcase
        w.min_valid = fill > 0;
        w.min_key = fill > 0 ? heap_key[1] : '0;
        w.entry_count = fill[10:0];
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        heap_word_t exp_w;
        if (!rst_n)
        begin
            fill = 0;
            issued = 0;
            errors = 0;
            checked = 0;
            owner_live = '{default: 1'b0};
            expected_words.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with no request outstanding");
                    errors++;
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    checked++;
                    if (status !== exp_w.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_w.status, status);
                        errors++;
                    end
                    if (min_valid !== exp_w.min_valid)
                    begin
                        $error("min_valid: expected %0d, got %0d",
                               exp_w.min_valid, min_valid);
                        errors++;
                    end
                    if (min_key !== exp_w.min_key)
                    begin
                        $error("min_key: expected %0d, got %0d", exp_w.min_key, min_key);
                        errors++;
                    end
                    if (new_handle !== exp_w.new_handle)
                    begin
                        $error("new_handle: expected %0d, got %0d",
                               exp_w.new_handle, new_handle);
                        errors++;
                    end
                    if (entry_count !== exp_w.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               exp_w.entry_count, entry_count);
                        errors++;
                    end
                end
            end
            if (start && !busy)
                expected_words.push_back(apply_request(req_type, int'(handle),
                                                       key_value));
        end
        pending = expected_words.size();
    end

endmodule

[tb/tb_indexed_min_heap_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_min_heap_unit: testbench of the indexed min-heap unit
// Drives directed and random request words with random idle bursts, lets
// the checker predict and compare every result word, then gives the verdict.
// ----------------------------------------------------------------------------
module tb_indexed_min_heap_unit;
    import ihp_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         req_type;
    logic [10:0]        handle;
    logic signed [31:0] key_value;
    logic               done;
    logic [1:0]         status;
    logic               min_valid;
    logic signed [31:0] min_key;
    logic [10:0]        new_handle;
    logic [10:0]        entry_count;
    int                 errors;
    int                 pending;
    int                 checked;
    int                 inserts_sent;
    int                 stall_cycles;

    indexed_min_heap_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .handle      (handle),
        .key_value   (key_value),
        .done        (done),
        .status      (status),
        .min_valid   (min_valid),
        .min_key     (min_key),
        .new_handle  (new_handle),
        .entry_count (entry_count)
    );

    indexed_min_heap_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .handle      (handle),
        .key_value   (key_value),
        .done        (done),
        .status      (status),
        .min_valid   (min_valid),
        .min_key     (min_key),
        .new_handle  (new_handle),
        .entry_count (entry_count),
        .errors      (errors),
        .pending     (pending),
        .checked     (checked)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_word(logic [2:0] r, logic [10:0] h, logic signed [31:0] k);
        req_type <= r;
        handle <= h;
        key_value <= k;
        start <= 1'b1;
        if (r == REQ_INSERT && inserts_sent < IHP_CAPACITY)
            inserts_sent++;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_key();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2, 3: return $signed($urandom_range(0, 8)) - 4;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic logic [10:0] pick_handle();
        case ($urandom_range(0, 19))
            0: return 11'd0;
            1: return 11'($urandom_range(0, 2047));
            2: return 11'd1024;
            default: return 11'($urandom_range(1, inserts_sent > 0 ? inserts_sent : 1));
        endcase
    endfunction

    task automatic random_word(int insert_pct);
        int         p;
        logic [2:0] r;
        p = $urandom_range(0, 99);
        if (p < insert_pct)
            r = REQ_INSERT;
        else if (p < insert_pct + 8)
            r = REQ_PEEK;
        else if (p < insert_pct + 25)
            r = REQ_DEL_MIN;
        else if (p < insert_pct + 45)
            r = REQ_DEL_HANDLE;
        else if (p < 96)
            r = REQ_MODIFY;
        else
            r = 3'($urandom_range(5, 7));
        send_word(r, pick_handle(), pick_key());
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        req_type = '0;
        handle = '0;
        key_value = '0;
        inserts_sent = 0;
        stall_cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(REQ_PEEK, 11'd0, 32'sd0);
        send_word(REQ_DEL_MIN, 11'd0, 32'sd0);
        send_word(REQ_DEL_HANDLE, 11'd0, 32'sd0);
        send_word(REQ_MODIFY, 11'd5, 32'sd0);
        send_word(REQ_INSERT, 11'd0, 32'sh7fffffff);
        send_word(REQ_INSERT, 11'd0, 32'sh80000000);
        send_word(REQ_INSERT, 11'd0, 32'sd0);
        send_word(REQ_INSERT, 11'd0, -32'sd1);
        send_word(REQ_INSERT, 11'd0, -32'sd1);
        send_word(REQ_INSERT, 11'd0, 32'sd0);
        send_word(REQ_PEEK, 11'd0, 32'sd0);
        send_word(REQ_MODIFY, 11'd1, 32'sh80000000);
        send_word(REQ_MODIFY, 11'd2, 32'sh7fffffff);
        send_word(REQ_DEL_HANDLE, 11'd3, 32'sd0);
        send_word(REQ_DEL_HANDLE, 11'd3, 32'sd0);
        send_word(REQ_INSERT, 11'd0, 32'sh7fffffff);
        send_word(REQ_DEL_HANDLE, 11'd7, 32'sd0);
        send_word(3'd5, 11'd2047, 32'sh55555555);
        send_word(3'd6, 11'd1024, -32'sd1);
        send_word(3'd7, 11'd1, 32'sd0);
        send_word(REQ_MODIFY, 11'd2047, 32'sd1);
        send_word(REQ_DEL_MIN, 11'd0, 32'sd0);
        send_word(REQ_DEL_MIN, 11'd0, 32'sd0);
        idle_cycles(3);

        // back to back in the last stretch
        for (int i = 0; i < 900; i++)
        begin
            random_word(40);
            if (i == 450)
                drain();
            else if (i < 800 && $urandom_range(0, 5) == 0)
                idle_cycles($urandom_range(1, 10));
        end

        drain();
        idle_cycles(50);
        $display("Checked %0d result words over insert, peek, delete, modify,",
                 checked);
        $display("unknown requests, stale handles and a full drain mid-run.");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
